>>> sv/sgcp_pkg.sv
// ----------------------------------------------------------------------------
// sgcp_pkg
// Shared types and constants for the scatter-gather copy planner: command
// codes, the input and result word layouts and the list entry layout.
// ----------------------------------------------------------------------------
package sgcp_pkg;

  // command codes
  localparam logic [1:0] CMD_LOAD_SRC = 2'd0;
  localparam logic [1:0] CMD_LOAD_DST = 2'd1;
  localparam logic [1:0] CMD_RUN      = 2'd2;

  // field widths
  localparam int ADDR_W  = 48;
  localparam int LEN_W   = 24;
  localparam int COUNT_W = 31;

  // a run emits at most this many segments
  localparam int MAX_RESULTS = 32;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0]         cmd;
    logic [ADDR_W-1:0]  entry_addr;
    logic [LEN_W-1:0]   entry_len;
    logic [COUNT_W-1:0] start_offset;
    logic [COUNT_W-1:0] byte_count;
  } sgcp_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  seg_src_addr;
    logic [ADDR_W-1:0]  seg_dst_addr;
    logic [LEN_W-1:0]   seg_len;
    logic [COUNT_W-1:0] total_copied;
    logic               last;
  } sgcp_out_t;

  // one scatter-gather list entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } list_entry_t;

endpackage

>>> sv/sgcp_list.sv
// ----------------------------------------------------------------------------
// sgcp_list
// Storage for one scatter-gather list: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sgcp_list #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  sgcp_pkg::list_entry_t wr_entry,
  input  logic [IDX_W-1:0]      rd_idx,
  output sgcp_pkg::list_entry_t rd_entry
);
  import sgcp_pkg::*;

  list_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_entry <= mem[rd_idx];
  end

endmodule

>>> sv/sgcp_seq.sv
// ----------------------------------------------------------------------------
// sgcp_seq
// Run sequencer: skips source entries covered by the start offset, then
// walks both lists one segment per step, holding back one segment so the
// final one can be flagged last. Drives the result output register.
// ----------------------------------------------------------------------------
module sgcp_seq #(
  parameter int CNT_W = 5,
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [sgcp_pkg::COUNT_W-1:0] run_offset,
  input  logic [sgcp_pkg::COUNT_W-1:0] run_count,
  input  logic [CNT_W-1:0]      src_cnt,
  input  logic [CNT_W-1:0]      dst_cnt,
  input  sgcp_pkg::list_entry_t src_rd,
  input  sgcp_pkg::list_entry_t dst_rd,
  output logic [IDX_W-1:0]      src_idx,
  output logic [IDX_W-1:0]      dst_idx,
  output logic                  busy,
  output logic                  done,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sgcp_pkg::sgcp_out_t   out_word
);
  import sgcp_pkg::*;

  typedef enum logic [2:0] {
    IDLE, SKIP_RD, SKIP, WALK_RD, REM, STEP, FINISH
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   si;
  logic [CNT_W-1:0]   di;
  logic [COUNT_W-1:0] soff;
  logic [LEN_W-1:0]   doff;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] total;
  logic [NRES_W-1:0]  nres;
  logic [LEN_W-1:0]   srem;
  logic [LEN_W-1:0]   drem;
  logic [ADDR_W-1:0]  seg_sa;
  logic [ADDR_W-1:0]  seg_da;
  logic               hold_valid;
  sgcp_out_t          hold;

  logic               out_free;
  logic               walk_ok;
  logic [COUNT_W-1:0] chunk_w;
  logic [LEN_W-1:0]   chunk;
  logic [COUNT_W-1:0] total_next;
  logic [NRES_W-1:0]  nres_next;
  logic               stall;
  logic               push;
  sgcp_out_t          push_word;

  assign src_idx  = si[IDX_W-1:0];
  assign dst_idx  = di[IDX_W-1:0];
  assign busy     = (state != IDLE);
  assign out_free = !out_valid || out_ready;
  assign done     = (state == FINISH) && out_free;
  assign walk_ok  = (si < src_cnt) && (di < dst_cnt) && (count != '0);

  // segment length: smallest of remaining count, source and destination
  always_comb begin
    chunk_w = count;
    if ({{(COUNT_W-LEN_W){1'b0}}, srem} < chunk_w) begin
      chunk_w = {{(COUNT_W-LEN_W){1'b0}}, srem};
    end
    if ({{(COUNT_W-LEN_W){1'b0}}, drem} < chunk_w) begin
      chunk_w = {{(COUNT_W-LEN_W){1'b0}}, drem};
    end
    chunk      = chunk_w[LEN_W-1:0];
    total_next = total + chunk_w;
    nres_next  = nres + NRES_W'(1);
    // a new segment needs the held one pushed out first
    stall      = (chunk != '0) && hold_valid && !out_free;
    // output register load: held segment on a new step, or the final word
    push       = ((state == STEP) && !stall && (chunk != '0) && hold_valid) || done;
    push_word  = hold_valid ? hold : '0;
    push_word.last = (state == FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      // output register: load a new word or drop the one taken
      out_valid <= push || (out_valid && !out_ready);
      if (push) begin
        out_word <= push_word;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            si         <= '0;
            di         <= '0;
            soff       <= run_offset;
            doff       <= '0;
            count      <= run_count;
            total      <= '0;
            nres       <= '0;
            hold_valid <= 1'b0;
            state      <= SKIP_RD;
          end
        end
        SKIP_RD: begin
          state <= SKIP;
        end
        // pass over whole source entries covered by the offset
        SKIP: begin
          if ((soff != '0) && (si < src_cnt) &&
              ({{(COUNT_W-LEN_W){1'b0}}, src_rd.len} <= soff)) begin
            soff  <= soff - {{(COUNT_W-LEN_W){1'b0}}, src_rd.len};
            si    <= si + CNT_W'(1);
            state <= SKIP_RD;
          end else begin
            state <= WALK_RD;
          end
        end
        WALK_RD: begin
          state <= REM;
        end
        // remaining bytes of both entries and segment addresses
        REM: begin
          if (!walk_ok) begin
            state <= FINISH;
          end else begin
            srem   <= ({{(COUNT_W-LEN_W){1'b0}}, src_rd.len} > soff) ?
                      (src_rd.len - soff[LEN_W-1:0]) : '0;
            drem   <= (dst_rd.len > doff) ? (dst_rd.len - doff) : '0;
            seg_sa <= src_rd.addr + {{(ADDR_W-COUNT_W){1'b0}}, soff};
            seg_da <= dst_rd.addr + {{(ADDR_W-LEN_W){1'b0}}, doff};
            state  <= STEP;
          end
        end
        // emit one segment and advance both lists
        STEP: begin
          if (!stall) begin
            if (chunk != '0) begin
              hold_valid <= 1'b1;
              hold       <= '{seg_src_addr: seg_sa, seg_dst_addr: seg_da,
                              seg_len: chunk, total_copied: total_next,
                              last: 1'b0};
              total      <= total_next;
              nres       <= nres_next;
            end
            count <= count - chunk_w;
            if (srem == chunk) begin
              si   <= si + CNT_W'(1);
              soff <= '0;
            end else begin
              soff <= soff + chunk_w;
            end
            if (drem == chunk) begin
              di   <= di + CNT_W'(1);
              doff <= '0;
            end else begin
              doff <= doff + chunk;
            end
            if ((chunk != '0) && (nres_next == NRES_W'(MAX_RESULTS))) begin
              state <= FINISH;
            end else begin
              state <= WALK_RD;
            end
          end
        end
        // final word: held segment flagged last, or the empty-run word
        FINISH: begin
          if (out_free) begin
            hold_valid <= 1'b0;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/scatter_gather_copy_planner.sv
// ----------------------------------------------------------------------------
// scatter_gather_copy_planner
// Loads source and destination scatter-gather lists and plans copy segments.
// ----------------------------------------------------------------------------
// A load word (source or destination) appends to its list; loads into a
// full list and unused commands are dropped. A run word holds in_ready low
// from the cycle after it is accepted until its final result has been taken
// into the output register: it reads and compares each source entry skipped
// by the start offset and the one that ends the skip, then for each walk
// step reads both lists, computes remainders and addresses and selects the
// segment, then makes the check that ends the walk (not made when the run
// stops at 32 segments) and emits the final word, and it waits while the
// output register stays full because the consumer stalls. Every run ends
// with exactly one word flagged last and empties both lists.
// ----------------------------------------------------------------------------
module scatter_gather_copy_planner #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgcp_pkg::sgcp_in_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output sgcp_pkg::sgcp_out_t out_word
);
  import sgcp_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [CNT_W-1:0] src_cnt;
  logic [CNT_W-1:0] dst_cnt;
  logic             accept;
  logic             src_wr;
  logic             dst_wr;
  logic             run_start;
  logic             busy;
  logic             done;
  logic [IDX_W-1:0] src_idx;
  logic [IDX_W-1:0] dst_idx;
  list_entry_t      wr_entry;
  list_entry_t      src_rd;
  list_entry_t      dst_rd;

  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign src_wr    = accept && (in_word.cmd == CMD_LOAD_SRC) &&
                     (src_cnt < CNT_W'(MAX_ENTRIES));
  assign dst_wr    = accept && (in_word.cmd == CMD_LOAD_DST) &&
                     (dst_cnt < CNT_W'(MAX_ENTRIES));
  assign run_start = accept && (in_word.cmd == CMD_RUN);
  assign wr_entry  = '{addr: in_word.entry_addr, len: in_word.entry_len};

  // fill counts; a finished run empties both lists
  always_ff @(posedge clk) begin
    if (rst) begin
      src_cnt <= '0;
      dst_cnt <= '0;
    end else if (done) begin
      src_cnt <= '0;
      dst_cnt <= '0;
    end else begin
      if (src_wr) begin
        src_cnt <= src_cnt + CNT_W'(1);
      end
      if (dst_wr) begin
        dst_cnt <= dst_cnt + CNT_W'(1);
      end
    end
  end

  sgcp_list #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_src_list (
    .clk      (clk),
    .wr_en    (src_wr),
    .wr_idx   (src_cnt[IDX_W-1:0]),
    .wr_entry (wr_entry),
    .rd_idx   (src_idx),
    .rd_entry (src_rd)
  );

  sgcp_list #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_dst_list (
    .clk      (clk),
    .wr_en    (dst_wr),
    .wr_idx   (dst_cnt[IDX_W-1:0]),
    .wr_entry (wr_entry),
    .rd_idx   (dst_idx),
    .rd_entry (dst_rd)
  );

  sgcp_seq #(
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (run_start),
    .run_offset (in_word.start_offset),
    .run_count  (in_word.byte_count),
    .src_cnt    (src_cnt),
    .dst_cnt    (dst_cnt),
    .src_rd     (src_rd),
    .dst_rd     (dst_rd),
    .src_idx    (src_idx),
    .dst_idx    (dst_idx),
    .busy       (busy),
    .done       (done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule
